>>> rtl/qabm_pkg.sv
// qabm_pkg: shared constants, types and helpers of the quad audio balance mixer
package qabm_pkg;

    // sample and gain formats
    localparam int SAMPLE_BITS    = 20;
    localparam int GAIN_FRAC_BITS = 15;
    localparam int GAIN_BITS      = 16;
    localparam int OUT_BITS       = 16;
    localparam int PROD_BITS      = SAMPLE_BITS + GAIN_BITS;
    localparam int SUM_BITS       = PROD_BITS + 2;
    localparam int SHIFT_BITS     = $clog2(GAIN_FRAC_BITS + 3);

    // configuration port
    localparam int HOST_BITS   = 3;
    localparam int LAYOUT_BITS = 3;
    localparam int PDATA_BITS  = 32;
    localparam int PADDR_BITS  = 5;
    localparam int REG_IDX_BITS = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_HOST_CHANNELS    = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_AUDIO_LAYOUT     = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_GAIN_FRONT_LEFT  = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_GAIN_FRONT_RIGHT = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_GAIN_REAR_LEFT   = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_GAIN_REAR_RIGHT  = 3'd5;

    // host channel counts
    localparam logic [HOST_BITS-1:0] HOST_MONO   = 3'd1;
    localparam logic [HOST_BITS-1:0] HOST_STEREO = 3'd2;
    localparam logic [HOST_BITS-1:0] HOST_QUAD   = 3'd4;

    // game audio layouts
    localparam logic [LAYOUT_BITS-1:0] LAYOUT_MONO      = 3'd0;
    localparam logic [LAYOUT_BITS-1:0] LAYOUT_STEREO_LR = 3'd1;
    localparam logic [LAYOUT_BITS-1:0] LAYOUT_STEREO_RL = 3'd2;
    localparam logic [LAYOUT_BITS-1:0] LAYOUT_QUAD_FLR  = 3'd3;
    localparam logic [LAYOUT_BITS-1:0] LAYOUT_QUAD_FRL  = 3'd4;
    localparam logic [LAYOUT_BITS-1:0] LAYOUT_QUAD_RLR  = 3'd5;
    localparam logic [LAYOUT_BITS-1:0] LAYOUT_QUAD_RRL  = 3'd6;
    localparam logic [LAYOUT_BITS-1:0] LAYOUT_SPLIT     = 3'd7;

    // reset values
    localparam logic [HOST_BITS-1:0]   HOST_RESET   = HOST_STEREO;
    localparam logic [LAYOUT_BITS-1:0] LAYOUT_RESET = LAYOUT_MONO;
    localparam logic [GAIN_BITS-1:0]   GAIN_UNITY   = 16'h8000;

    // number of samples averaged into one result
    typedef enum logic [1:0] {
        AVG_ONE,
        AVG_PAIR,
        AVG_QUAD
    } t_avg;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [HOST_BITS-1:0]   host_channels;
        logic [LAYOUT_BITS-1:0] audio_layout;
        logic [GAIN_BITS-1:0]   gain_front_left;
        logic [GAIN_BITS-1:0]   gain_front_right;
        logic [GAIN_BITS-1:0]   gain_rear_left;
        logic [GAIN_BITS-1:0]   gain_rear_right;
    } t_cfg;

    // scaled frame between the scale and mix stages
    typedef struct packed {
        logic                        valid;
        logic signed [PROD_BITS-1:0] fl;
        logic signed [PROD_BITS-1:0] fr;
        logic signed [PROD_BITS-1:0] rl;
        logic signed [PROD_BITS-1:0] rr;
        logic                        swap;
        logic                        eob;
    } t_prod;

    // sign extend a scaled sample to sum width
    function automatic logic signed [SUM_BITS-1:0] sext_prod(
        input logic signed [PROD_BITS-1:0] p
    );
        return {{(SUM_BITS-PROD_BITS){p[PROD_BITS-1]}}, p};
    endfunction

    // divide by 2^(frac + extra) toward zero, then saturate to 16 bits
    function automatic logic signed [OUT_BITS-1:0] finish(
        input logic signed [SUM_BITS-1:0] sum,
        input t_avg                       avg
    );
        logic [SHIFT_BITS-1:0]      sh;
        logic signed [SUM_BITS-1:0] bias;
        logic signed [SUM_BITS-1:0] q;
        logic signed [SUM_BITS-1:0] sat_hi;
        logic signed [SUM_BITS-1:0] sat_lo;
        sat_hi = SUM_BITS'(32767);
        sat_lo = ~sat_hi;
        case (avg)
            AVG_ONE:  sh = SHIFT_BITS'(GAIN_FRAC_BITS);
            AVG_PAIR: sh = SHIFT_BITS'(GAIN_FRAC_BITS + 1);
            AVG_QUAD: sh = SHIFT_BITS'(GAIN_FRAC_BITS + 2);
            default:  sh = SHIFT_BITS'(GAIN_FRAC_BITS);
        endcase
        // negative values get a bias so the shift rounds toward zero
        bias = sum[SUM_BITS-1] ? ((SUM_BITS'(1) << sh) - SUM_BITS'(1)) : '0;
        q    = (sum + bias) >>> sh;
        if (q > sat_hi) begin
            q = sat_hi;
        end else if (q < sat_lo) begin
            q = sat_lo;
        end
        return q[OUT_BITS-1:0];
    endfunction

endpackage

>>> rtl/qabm_if.sv
// qabm_if: frame and result channel interfaces of the quad audio balance mixer

// input frame channel
interface qabm_in_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [qabm_pkg::SAMPLE_BITS-1:0]   front_left;
    logic signed [qabm_pkg::SAMPLE_BITS-1:0]   front_right;
    logic signed [qabm_pkg::SAMPLE_BITS-1:0]   rear_left;
    logic signed [qabm_pkg::SAMPLE_BITS-1:0]   rear_right;
    logic                                      swap_sides;
    logic                                      end_of_block;

    modport source (
        output valid, front_left, front_right, rear_left, rear_right,
               swap_sides, end_of_block,
        input  ready
    );
    modport sink (
        input  valid, front_left, front_right, rear_left, rear_right,
               swap_sides, end_of_block,
        output ready
    );
endinterface

// host result channel
interface qabm_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [qabm_pkg::OUT_BITS-1:0]   out_ch0;
    logic signed [qabm_pkg::OUT_BITS-1:0]   out_ch1;
    logic signed [qabm_pkg::OUT_BITS-1:0]   out_ch2;
    logic signed [qabm_pkg::OUT_BITS-1:0]   out_ch3;
    logic                                   block_done;

    modport source (
        output valid, out_ch0, out_ch1, out_ch2, out_ch3, block_done,
        input  ready
    );
    modport sink (
        input  valid, out_ch0, out_ch1, out_ch2, out_ch3, block_done,
        output ready
    );
endinterface

>>> rtl/quad_audio_balance_mixer_top.sv
// quad_audio_balance_mixer_top: top level of the quad audio balance mixer
//
// Frames of four samples (front left/right, rear left/right) enter on i_in with a
// per-frame swap request and an end-of-block mark. Each sample is scaled by its
// balance gain, then routed or averaged into 1, 2 or 4 host channels on o_out
// according to host_channels and audio_layout; unused channels read zero and
// block_done copies end_of_block.
// Channels use valid/ready; an item moves when both are high. Registers are
// written through the APB-style port (pready always high); the user must write
// them only while no frame is in flight, the block itself does not enforce it.
// From frame accept a result passes the input register, gain multiplier register
// and result register in turn. Throughput: one frame per cycle while the receiver
// holds ready, set by the four parallel gain multipliers feeding the mix stage.
// Each stage takes a new item when it is empty or passes its item on, so the
// block keeps accepting while a finished result waits, until all three stages
// are full. When the receiver holds ready low the result stays put and the
// stages behind it fill, then i_in.ready drops.
// Reset (synchronous, active low) empties every stage and loads host_channels
// 2, layout mono and unity gains.
module quad_audio_balance_mixer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    qabm_in_if.sink                          i_in,
    qabm_out_if.source                       o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [qabm_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [qabm_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [qabm_pkg::PDATA_BITS-1:0]  prdata,
    output logic                             pready
);

    qabm_pkg::t_cfg  cfg;
    qabm_pkg::t_prod prod;
    logic            prod_ready;

    // configuration registers
    qabm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input register and gain multipliers
    qabm_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (cfg),
        .o_prod       (prod),
        .i_prod_ready (prod_ready)
    );

    // routing, averaging and result register
    qabm_mix u_mix (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_prod       (prod),
        .o_prod_ready (prod_ready),
        .i_cfg        (cfg),
        .o_out        (o_out)
    );

endmodule

>>> rtl/qabm_cfg.sv
// qabm_cfg: register file behind the configuration port
module qabm_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qabm_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [qabm_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [qabm_pkg::PDATA_BITS-1:0]     prdata,
    output logic                                pready,
    output qabm_pkg::t_cfg                      o_cfg
);

    qabm_pkg::t_cfg                        r_cfg;
    logic                                  wr_en;
    logic [qabm_pkg::REG_IDX_BITS-1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[qabm_pkg::PADDR_BITS-1:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.host_channels    <= qabm_pkg::HOST_RESET;
            r_cfg.audio_layout     <= qabm_pkg::LAYOUT_RESET;
            r_cfg.gain_front_left  <= qabm_pkg::GAIN_UNITY;
            r_cfg.gain_front_right <= qabm_pkg::GAIN_UNITY;
            r_cfg.gain_rear_left   <= qabm_pkg::GAIN_UNITY;
            r_cfg.gain_rear_right  <= qabm_pkg::GAIN_UNITY;
        end else if (wr_en) begin
            case (reg_idx)
                qabm_pkg::REG_HOST_CHANNELS:
                    r_cfg.host_channels <= pwdata[qabm_pkg::HOST_BITS-1:0];
                qabm_pkg::REG_AUDIO_LAYOUT:
                    r_cfg.audio_layout <= pwdata[qabm_pkg::LAYOUT_BITS-1:0];
                qabm_pkg::REG_GAIN_FRONT_LEFT:
                    r_cfg.gain_front_left <= pwdata[qabm_pkg::GAIN_BITS-1:0];
                qabm_pkg::REG_GAIN_FRONT_RIGHT:
                    r_cfg.gain_front_right <= pwdata[qabm_pkg::GAIN_BITS-1:0];
                qabm_pkg::REG_GAIN_REAR_LEFT:
                    r_cfg.gain_rear_left <= pwdata[qabm_pkg::GAIN_BITS-1:0];
                qabm_pkg::REG_GAIN_REAR_RIGHT:
                    r_cfg.gain_rear_right <= pwdata[qabm_pkg::GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            qabm_pkg::REG_HOST_CHANNELS:
                prdata = qabm_pkg::PDATA_BITS'(r_cfg.host_channels);
            qabm_pkg::REG_AUDIO_LAYOUT:
                prdata = qabm_pkg::PDATA_BITS'(r_cfg.audio_layout);
            qabm_pkg::REG_GAIN_FRONT_LEFT:
                prdata = qabm_pkg::PDATA_BITS'(r_cfg.gain_front_left);
            qabm_pkg::REG_GAIN_FRONT_RIGHT:
                prdata = qabm_pkg::PDATA_BITS'(r_cfg.gain_front_right);
            qabm_pkg::REG_GAIN_REAR_LEFT:
                prdata = qabm_pkg::PDATA_BITS'(r_cfg.gain_rear_left);
            qabm_pkg::REG_GAIN_REAR_RIGHT:
                prdata = qabm_pkg::PDATA_BITS'(r_cfg.gain_rear_right);
            default:
                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/qabm_scale.sv
// qabm_scale: input register and per-channel balance gain multipliers
module qabm_scale (
    input  logic             i_clk,
    input  logic             i_rst_n,
    qabm_in_if.sink          i_in,
    input  qabm_pkg::t_cfg   i_cfg,
    output qabm_pkg::t_prod  o_prod,
    input  logic             i_prod_ready
);

    logic                                    r_v1;
    logic signed [qabm_pkg::SAMPLE_BITS-1:0] r_fl;
    logic signed [qabm_pkg::SAMPLE_BITS-1:0] r_fr;
    logic signed [qabm_pkg::SAMPLE_BITS-1:0] r_rl;
    logic signed [qabm_pkg::SAMPLE_BITS-1:0] r_rr;
    logic                                    r_swap1;
    logic                                    r_eob1;
    qabm_pkg::t_prod                         r_prod;
    logic                                    rdy1;
    logic                                    rdy2;
    logic signed [qabm_pkg::PROD_BITS-1:0]   n_fl;
    logic signed [qabm_pkg::PROD_BITS-1:0]   n_fr;
    logic signed [qabm_pkg::PROD_BITS-1:0]   n_rl;
    logic signed [qabm_pkg::PROD_BITS-1:0]   n_rr;

    // each stage moves on when empty or when the next one takes its item
    assign rdy2       = !r_prod.valid || i_prod_ready;
    assign rdy1       = !r_v1 || rdy2;
    assign i_in.ready = rdy1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_in.valid;
        end
        if (rdy1 && i_in.valid) begin
            r_fl    <= i_in.front_left;
            r_fr    <= i_in.front_right;
            r_rl    <= i_in.rear_left;
            r_rr    <= i_in.rear_right;
            r_swap1 <= i_in.swap_sides;
            r_eob1  <= i_in.end_of_block;
        end
    end

    // four gain multipliers, gains taken as unsigned
    assign n_fl = r_fl * $signed({1'b0, i_cfg.gain_front_left});
    assign n_fr = r_fr * $signed({1'b0, i_cfg.gain_front_right});
    assign n_rl = r_rl * $signed({1'b0, i_cfg.gain_rear_left});
    assign n_rr = r_rr * $signed({1'b0, i_cfg.gain_rear_right});

    // product register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod.valid <= 1'b0;
        end else if (rdy2) begin
            r_prod.valid <= r_v1;
        end
        if (rdy2 && r_v1) begin
            r_prod.fl   <= n_fl;
            r_prod.fr   <= n_fr;
            r_prod.rl   <= n_rl;
            r_prod.rr   <= n_rr;
            r_prod.swap <= r_swap1;
            r_prod.eob  <= r_eob1;
        end
    end

    assign o_prod = r_prod;

    // an accepted frame is held in the input register next cycle
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v1)
        else $error("accepted frame lost at input register");

    // a full input register with a blocked product stage keeps its item
    a_stall_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !rdy2) |=> (r_v1 && $stable(r_fl) && $stable(r_eob1)))
        else $error("input register changed while stalled");

endmodule

>>> rtl/qabm_mix.sv
// qabm_mix: channel routing, downmix averages, rounding and result register
module qabm_mix (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  qabm_pkg::t_prod  i_prod,
    output logic             o_prod_ready,
    input  qabm_pkg::t_cfg   i_cfg,
    qabm_out_if.source       o_out
);

    logic                                    r_ov;
    logic signed [qabm_pkg::OUT_BITS-1:0]    r_ch0;
    logic signed [qabm_pkg::OUT_BITS-1:0]    r_ch1;
    logic signed [qabm_pkg::OUT_BITS-1:0]    r_ch2;
    logic signed [qabm_pkg::OUT_BITS-1:0]    r_ch3;
    logic                                    r_done;
    logic signed [qabm_pkg::SUM_BITS-1:0]    fl;
    logic signed [qabm_pkg::SUM_BITS-1:0]    fr;
    logic signed [qabm_pkg::SUM_BITS-1:0]    rl;
    logic signed [qabm_pkg::SUM_BITS-1:0]    rr;
    logic signed [qabm_pkg::SUM_BITS-1:0]    sum_a;
    logic signed [qabm_pkg::SUM_BITS-1:0]    sum_b;
    logic signed [qabm_pkg::SUM_BITS-1:0]    sum_c;
    logic signed [qabm_pkg::SUM_BITS-1:0]    sum_d;
    qabm_pkg::t_avg                          avg;
    logic signed [qabm_pkg::OUT_BITS-1:0]    va;
    logic signed [qabm_pkg::OUT_BITS-1:0]    vb;
    logic signed [qabm_pkg::OUT_BITS-1:0]    vc;
    logic signed [qabm_pkg::OUT_BITS-1:0]    vd;
    logic                                    layout_flip;
    logic                                    swap;
    logic                                    take;
    logic signed [qabm_pkg::OUT_BITS-1:0]    n_ch0;
    logic signed [qabm_pkg::OUT_BITS-1:0]    n_ch1;
    logic signed [qabm_pkg::OUT_BITS-1:0]    n_ch2;
    logic signed [qabm_pkg::OUT_BITS-1:0]    n_ch3;

    assign o_prod_ready = !r_ov || o_out.ready;
    assign take         = i_prod.valid && o_prod_ready;

    assign fl = qabm_pkg::sext_prod(i_prod.fl);
    assign fr = qabm_pkg::sext_prod(i_prod.fr);
    assign rl = qabm_pkg::sext_prod(i_prod.rl);
    assign rr = qabm_pkg::sext_prod(i_prod.rr);

    // layouts with reversed sides invert the swap request
    assign layout_flip =
        (i_cfg.host_channels == qabm_pkg::HOST_STEREO ||
         i_cfg.host_channels == qabm_pkg::HOST_QUAD) &&
        (i_cfg.audio_layout == qabm_pkg::LAYOUT_STEREO_RL ||
         i_cfg.audio_layout == qabm_pkg::LAYOUT_QUAD_FRL ||
         i_cfg.audio_layout == qabm_pkg::LAYOUT_QUAD_RRL);
    assign swap = i_prod.swap ^ layout_flip;

    // pick the four sums feeding the a, b, c, d results
    always_comb begin
        sum_a = fl + fr + rl + rr;
        sum_b = sum_a;
        sum_c = sum_a;
        sum_d = sum_a;
        avg   = qabm_pkg::AVG_QUAD;
        if (i_cfg.host_channels == qabm_pkg::HOST_STEREO) begin
            sum_a = fl + rl;
            sum_b = fr + rr;
            avg   = qabm_pkg::AVG_PAIR;
        end else if (i_cfg.host_channels == qabm_pkg::HOST_QUAD) begin
            case (i_cfg.audio_layout)
                qabm_pkg::LAYOUT_MONO: ;
                qabm_pkg::LAYOUT_STEREO_LR, qabm_pkg::LAYOUT_STEREO_RL: begin
                    sum_a = fl + fr;
                    sum_b = rl + rr;
                    sum_c = sum_a;
                    sum_d = sum_b;
                    avg   = qabm_pkg::AVG_PAIR;
                end
                qabm_pkg::LAYOUT_QUAD_FLR, qabm_pkg::LAYOUT_QUAD_FRL: begin
                    sum_a = fl;
                    sum_b = fr;
                    sum_c = rl;
                    sum_d = rr;
                    avg   = qabm_pkg::AVG_ONE;
                end
                qabm_pkg::LAYOUT_QUAD_RLR, qabm_pkg::LAYOUT_QUAD_RRL: begin
                    sum_a = rl;
                    sum_b = rr;
                    sum_c = fl;
                    sum_d = fr;
                    avg   = qabm_pkg::AVG_ONE;
                end
                default: begin
                    sum_a = fl + rl;
                    sum_b = fl + rr;
                    sum_c = fr + rl;
                    sum_d = fr + rr;
                    avg   = qabm_pkg::AVG_PAIR;
                end
            endcase
        end
    end

    // truncate toward zero and saturate
    assign va = qabm_pkg::finish(sum_a, avg);
    assign vb = qabm_pkg::finish(sum_b, avg);
    assign vc = qabm_pkg::finish(sum_c, avg);
    assign vd = qabm_pkg::finish(sum_d, avg);

    // channel order and unused channels
    always_comb begin
        n_ch0 = '0;
        n_ch1 = '0;
        n_ch2 = '0;
        n_ch3 = '0;
        case (i_cfg.host_channels)
            qabm_pkg::HOST_MONO: begin
                n_ch0 = va;
            end
            qabm_pkg::HOST_STEREO: begin
                n_ch0 = swap ? vb : va;
                n_ch1 = swap ? va : vb;
            end
            qabm_pkg::HOST_QUAD: begin
                n_ch0 = swap ? vb : va;
                n_ch1 = swap ? va : vb;
                n_ch2 = swap ? vd : vc;
                n_ch3 = swap ? vc : vd;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (o_prod_ready) begin
            r_ov <= i_prod.valid;
        end
        if (take) begin
            r_ch0  <= n_ch0;
            r_ch1  <= n_ch1;
            r_ch2  <= n_ch2;
            r_ch3  <= n_ch3;
            r_done <= i_prod.eob;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_ch0    = r_ch0;
    assign o_out.out_ch1    = r_ch1;
    assign o_out.out_ch2    = r_ch2;
    assign o_out.out_ch3    = r_ch3;
    assign o_out.block_done = r_done;

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

    // a taken frame shows up as a result next cycle
    a_take_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_out.valid)
        else $error("taken frame did not reach the result register");

    // two host channels leave the upper pair silent
    a_stereo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cfg.host_channels == qabm_pkg::HOST_STEREO)
        |=> (o_out.out_ch2 == '0 && o_out.out_ch3 == '0))
        else $error("unused channel not zero in stereo mode");

    // one host channel leaves the other three silent
    a_mono_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cfg.host_channels == qabm_pkg::HOST_MONO)
        |=> (o_out.out_ch1 == '0 && o_out.out_ch2 == '0 && o_out.out_ch3 == '0))
        else $error("unused channel not zero in mono mode");

endmodule
